[rtl/core/xfq_pkg.sv]
// Shared package for the xor-filter membership engine.
// Holds widths, function codes, hash constants, the queue item type and
// small arithmetic helpers. No dependencies.
package xfq_pkg;

	// Default number of entries per table segment.
	localparam int unsigned MAX_SEGMENT_DEF = 4096;

	// Field widths.
	localparam int FUNC_W = 2;
	localparam int IDX_W  = 14;
	localparam int FP_W   = 8;
	localparam int KEY_W  = 64;
	localparam int TAIL_W = 32;
	localparam int SEG_W  = 13;
	localparam int HALF_W = 32;

	// Function codes of an input item.
	localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QKEY    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QPOINT  = 2'd2;

	// Mixer constants.
	localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam int MIX_SHIFT  = 33;
	localparam int FOLD_SHIFT = 32;

	// Hash lanes: three slot hashes plus the fingerprint hash.
	localparam int NUM_HASH  = 3;
	localparam int NUM_LANES = 4;
	localparam int FP_LANE   = 3;

	// Configuration port.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 64;
	localparam int REG_SEL_BIT = 3;
	localparam logic REG_SEED = 1'b0;
	localparam logic REG_SEG  = 1'b1;

	// Decoupling queue and pipeline depth.
	localparam int QUEUE_DEPTH = 2;
	// Clock edges from the accepting edge to the edge that samples the result strobe.
	localparam int LATENCY = 8;

	typedef struct packed {
		logic              is_write;
		logic              is_query;
		logic [KEY_W-1:0]  key;
		logic [IDX_W-1:0]  index;
		logic [FP_W-1:0]   value;
	} item_t;

	function automatic logic [KEY_W-1:0] xorshift(input logic [KEY_W-1:0] h);
		xorshift = h ^ (h >> MIX_SHIFT);
	endfunction

	// Full 64-bit product of two 32-bit halves.
	function automatic logic [KEY_W-1:0] mul_full(input logic [HALF_W-1:0] a,
			input logic [HALF_W-1:0] b);
		mul_full = {{HALF_W{1'b0}}, a} * {{HALF_W{1'b0}}, b};
	endfunction

	// Low 32 bits of the product of two 32-bit halves.
	function automatic logic [HALF_W-1:0] mul_low(input logic [HALF_W-1:0] a,
			input logic [HALF_W-1:0] b);
		mul_low = a * b;
	endfunction

endpackage

[rtl/core/xor_filter_membership_query.sv]
// Top level of the xor-filter membership engine: configuration registers
// and the front end, queue and back end. Depends on xfq_pkg, xfq_front,
// xfq_queue and xfq_back.
//
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+------------------------------------------
// request   | start in, busy out             | func, entry_index, entry_value,
//           |                                | key_value, point_tail
// result    | done out (one-cycle strobe)    | is_member
// config    | psel, penable, pwrite, pready  | paddr, pwdata, prdata (64-bit data)
//
// The engine takes one request per clock cycle. A query passes in order through
// the queue, the back end's first stage, the stages that run the two 64-bit
// mixers (each multiply split into 32-bit partial products) and the multiply-high,
// the table read, and the output register that raises the done strobe. Writes and
// unused function codes give no result. The receiver cannot stall; busy follows
// the queue's full flag, and since the back end drains its head entry in every
// cycle the queue never holds more than one entry, so busy never rises.
// Reset (arst_n, asynchronous, active low) clears the registers and all
// control state; the fingerprint table is not cleared and must be written
// before it is queried, so there is no clearing pass.
module xor_filter_membership_query #(
	parameter int unsigned MAX_SEGMENT = xfq_pkg::MAX_SEGMENT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Request channel.
	input  logic                            start,
	output logic                            busy,
	input  logic [xfq_pkg::FUNC_W-1:0]      func,
	input  logic [xfq_pkg::IDX_W-1:0]       entry_index,
	input  logic [xfq_pkg::FP_W-1:0]        entry_value,
	input  logic [xfq_pkg::KEY_W-1:0]       key_value,
	input  logic [xfq_pkg::TAIL_W-1:0]      point_tail,

	// Result channel.
	output logic                            done,
	output logic                            is_member,

	// Configuration port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [xfq_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [xfq_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [xfq_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	// Register file: hash seed at byte address 0, segment length at 8.
	// Only the address bit that tells the two apart is decoded.
	logic [xfq_pkg::KEY_W-1:0] seed_q;
	logic [xfq_pkg::SEG_W-1:0] seg_q;
	logic                      reg_sel;
	logic                      cfg_write;

	assign pready    = 1'b1;
	assign reg_sel   = paddr[xfq_pkg::REG_SEL_BIT];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			seg_q  <= '0;
		end else if (cfg_write) begin
			if (reg_sel == xfq_pkg::REG_SEED) begin
				seed_q <= pwdata;
			end else begin
				seg_q <= pwdata[xfq_pkg::SEG_W-1:0];
			end
		end
	end

	// Reads return the addressed register, zero-extended to the bus width.
	assign prdata = (reg_sel == xfq_pkg::REG_SEED) ? seed_q :
		{{(xfq_pkg::APB_DATA_W - xfq_pkg::SEG_W){1'b0}}, seg_q};

	// The front end classifies each request and folds points to keys. Writes
	// and queries share one ordered stream, so a query always sees the table
	// as left by every write accepted before it.
	logic           queue_full;
	logic           push;
	xfq_pkg::item_t push_item;
	logic           head_valid;
	xfq_pkg::item_t head_item;

	xfq_front #(
		.MAX_SEGMENT(MAX_SEGMENT)
	) u_front (
		.start       (start),
		.busy        (busy),
		.func        (func),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.key_value   (key_value),
		.point_tail  (point_tail),
		.full        (queue_full),
		.push        (push),
		.item        (push_item)
	);

	xfq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// The back end hashes, reads the three table copies and compares.
	xfq_back #(
		.MAX_SEGMENT(MAX_SEGMENT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (head_valid),
		.in_item        (head_item),
		.hash_seed      (seed_q),
		.segment_length (seg_q),
		.done           (done),
		.is_member      (is_member)
	);

endmodule

[rtl/core/xfq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module xfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/xfq_front.sv]
// Front end: accepts items, folds 96-bit points to 64-bit keys and drops
// items that give nothing. Depends on xfq_pkg.
module xfq_front #(
	parameter int unsigned MAX_SEGMENT = xfq_pkg::MAX_SEGMENT_DEF
) (
	input  logic                        start,
	output logic                        busy,
	input  logic [xfq_pkg::FUNC_W-1:0]  func,
	input  logic [xfq_pkg::IDX_W-1:0]   entry_index,
	input  logic [xfq_pkg::FP_W-1:0]    entry_value,
	input  logic [xfq_pkg::KEY_W-1:0]   key_value,
	input  logic [xfq_pkg::TAIL_W-1:0]  point_tail,
	input  logic                        full,
	output logic                        push,
	output xfq_pkg::item_t              item
);

	localparam int unsigned TABLE_DEPTH = 3 * MAX_SEGMENT;

	logic                       accept;
	logic                       in_range;
	logic [xfq_pkg::KEY_W-1:0]  tail_ext;

	assign busy     = full;
	assign accept   = start && !full;
	assign in_range = (32'(entry_index) < TABLE_DEPTH);
	assign tail_ext = {{(xfq_pkg::KEY_W - xfq_pkg::TAIL_W){1'b0}}, point_tail};

	always_comb begin
		item.is_write = 1'b0;
		item.is_query = 1'b0;
		item.key      = key_value;
		item.index    = entry_index;
		item.value    = entry_value;
		case (func)
			xfq_pkg::FUNC_WRITE: begin
				item.is_write = in_range;
			end
			xfq_pkg::FUNC_QKEY: begin
				item.is_query = 1'b1;
			end
			xfq_pkg::FUNC_QPOINT: begin
				item.is_query = 1'b1;
				item.key      = key_value ^ tail_ext ^ (tail_ext << xfq_pkg::FOLD_SHIFT);
			end
			default: begin
				item.is_query = 1'b0;
			end
		endcase
	end

	assign push = accept && (item.is_write || item.is_query);

endmodule

[rtl/core/xfq_queue.sv]
// Short FIFO between the front end and the back end. The head entry is
// handed on in every cycle in which the queue holds one. Depends on xfq_pkg.
module xfq_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xfq_pkg::item_t push_item,
	output logic           full,
	output logic           head_valid,
	output xfq_pkg::item_t head_item
);

	localparam int DEPTH = xfq_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	xfq_pkg::item_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign head_valid = (count_q != '0);
	assign pop        = head_valid;
	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/xfq_back.sv]
// Back end: hashing pipeline, three table copies and the membership compare.
// Depends on xfq_pkg and xfq_ram.
module xfq_back #(
	parameter int unsigned MAX_SEGMENT = xfq_pkg::MAX_SEGMENT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  xfq_pkg::item_t             in_item,
	input  logic [xfq_pkg::KEY_W-1:0]  hash_seed,
	input  logic [xfq_pkg::SEG_W-1:0]  segment_length,
	output logic                       done,
	output logic                       is_member
);

	localparam int KW    = xfq_pkg::KEY_W;
	localparam int HW    = xfq_pkg::HALF_W;
	localparam int SW    = xfq_pkg::SEG_W;
	localparam int LANES = xfq_pkg::NUM_LANES;
	localparam int NH    = xfq_pkg::NUM_HASH;
	localparam int PROD_W = HW + SW;
	localparam int POS_W  = SW + 2;
	localparam int unsigned TABLE_DEPTH = 3 * MAX_SEGMENT;
	localparam int TAB_W = $clog2(TABLE_DEPTH);
	localparam int unsigned SEG_REG_MAX = (1 << SW) - 1;
	localparam logic [SW-1:0] LEN_CAP = (MAX_SEGMENT < SEG_REG_MAX) ?
		SW'(MAX_SEGMENT) : SW'(SEG_REG_MAX);

	// Segment length, saturated to the segment size.
	logic [SW-1:0] len;
	assign len = (segment_length > LEN_CAP) ? LEN_CAP : segment_length;

	// Stage 1: item from the queue.
	logic           vld_s1;
	xfq_pkg::item_t item_s1;

	// Stage 2: mixer inputs.
	logic                  vld_s2, wr_s2, qry_s2;
	logic [xfq_pkg::IDX_W-1:0] idx_s2;
	logic [xfq_pkg::FP_W-1:0]  val_s2;
	logic [KW-1:0]         x_s2 [LANES];

	// Stage 3: first multiply partial products.
	logic                  vld_s3, wr_s3, qry_s3;
	logic [xfq_pkg::IDX_W-1:0] idx_s3;
	logic [xfq_pkg::FP_W-1:0]  val_s3;
	logic [KW-1:0]         ll_s3 [LANES];
	logic [HW-1:0]         cr_s3 [LANES];

	// Stage 4: second multiply partial products.
	logic                  vld_s4, wr_s4, qry_s4;
	logic [xfq_pkg::IDX_W-1:0] idx_s4;
	logic [xfq_pkg::FP_W-1:0]  val_s4;
	logic [KW-1:0]         ll_s4 [LANES];
	logic [HW-1:0]         cr_s4 [LANES];

	// Stage 5: multiply-high partial products and fingerprint.
	logic                  vld_s5, wr_s5, qry_s5;
	logic [xfq_pkg::IDX_W-1:0] idx_s5;
	logic [xfq_pkg::FP_W-1:0]  val_s5;
	logic [xfq_pkg::FP_W-1:0]  fp_s5;
	logic [PROD_W-1:0]     plo_s5 [NH];
	logic [PROD_W-1:0]     phi_s5 [NH];

	// Stage 6: table read data returns.
	logic                  vld_s6, qry_s6, nofilt_s6;
	logic [xfq_pkg::FP_W-1:0]  fp_s6;

	logic                  done_q, member_q;

	// Combinational values between stages.
	logic [KW-1:0]         x_d  [LANES];
	logic [KW-1:0]         h_d  [LANES];
	logic [KW-1:0]         ll_d [LANES];
	logic [HW-1:0]         cr_d [LANES];
	logic [KW-1:0]         m_d  [LANES];
	logic [KW-1:0]         g_d  [LANES];
	logic [KW-1:0]         ll2_d [LANES];
	logic [HW-1:0]         cr2_d [LANES];
	logic [KW-1:0]         m2_d [LANES];
	logic [KW-1:0]         f_d  [LANES];
	logic [PROD_W-1:0]     plo_d [NH];
	logic [PROD_W-1:0]     phi_d [NH];
	logic [PROD_W:0]       hsum_d [NH];
	logic [SW-1:0]         slot_d [NH];
	logic [POS_W-1:0]      off_d  [NH];
	logic [POS_W-1:0]      pos_d  [NH];
	logic [TAB_W-1:0]      raddr_d [NH];
	logic [xfq_pkg::FP_W-1:0] rdata_d [NH];
	logic [xfq_pkg::FP_W-1:0] xor_d;

	// Stage 1 -> 2: keys offset by seed and lane number; the last lane is the raw key.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (l == xfq_pkg::FP_LANE) begin
				x_d[l] = item_s1.key;
			end else begin
				x_d[l] = item_s1.key + hash_seed + KW'(l);
			end
		end
	end

	// Stage 2 -> 3: first xorshift and the first constant multiply in 32-bit parts.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			h_d[l]  = xfq_pkg::xorshift(x_s2[l]);
			ll_d[l] = xfq_pkg::mul_full(h_d[l][HW-1:0], xfq_pkg::MIX_C1[HW-1:0]);
			cr_d[l] = xfq_pkg::mul_low(h_d[l][KW-1:HW], xfq_pkg::MIX_C1[HW-1:0])
				+ xfq_pkg::mul_low(h_d[l][HW-1:0], xfq_pkg::MIX_C1[KW-1:HW]);
		end
	end

	// Stage 3 -> 4: finish the first product, second xorshift and multiply.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			m_d[l]   = ll_s3[l] + {cr_s3[l], {HW{1'b0}}};
			g_d[l]   = xfq_pkg::xorshift(m_d[l]);
			ll2_d[l] = xfq_pkg::mul_full(g_d[l][HW-1:0], xfq_pkg::MIX_C2[HW-1:0]);
			cr2_d[l] = xfq_pkg::mul_low(g_d[l][KW-1:HW], xfq_pkg::MIX_C2[HW-1:0])
				+ xfq_pkg::mul_low(g_d[l][HW-1:0], xfq_pkg::MIX_C2[KW-1:HW]);
		end
	end

	// Stage 4 -> 5: final xorshift, then the hash times the segment length in two halves.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			m2_d[l] = ll_s4[l] + {cr_s4[l], {HW{1'b0}}};
			f_d[l]  = xfq_pkg::xorshift(m2_d[l]);
		end
		for (int i = 0; i < NH; i++) begin
			plo_d[i] = {{SW{1'b0}}, f_d[i][HW-1:0]} * {{HW{1'b0}}, len};
			phi_d[i] = {{SW{1'b0}}, f_d[i][KW-1:HW]} * {{HW{1'b0}}, len};
		end
	end

	// Stage 5: the high word of the product is the slot; add the segment base.
	always_comb begin
		for (int i = 0; i < NH; i++) begin
			hsum_d[i]  = {1'b0, phi_s5[i]} + (PROD_W + 1)'(plo_s5[i] >> HW);
			slot_d[i]  = hsum_d[i][HW +: SW];
			off_d[i]   = POS_W'(i) * {2'b00, len};
			pos_d[i]   = {2'b00, slot_d[i]} + off_d[i];
			raddr_d[i] = TAB_W'(pos_d[i]);
		end
	end

	// Every copy of the table takes every write and serves one of the three reads.
	for (genvar i = 0; i < NH; i++) begin : g_table
		xfq_ram #(
			.WIDTH(xfq_pkg::FP_W),
			.DEPTH(TABLE_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (vld_s5 && wr_s5),
			.waddr (TAB_W'(idx_s5)),
			.wdata (val_s5),
			.raddr (raddr_d[i]),
			.rdata (rdata_d[i])
		);
	end

	assign xor_d = rdata_d[0] ^ rdata_d[1] ^ rdata_d[2];

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			vld_s6   <= 1'b0;
			done_q   <= 1'b0;
			member_q <= 1'b0;
		end else begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			vld_s5   <= vld_s4;
			vld_s6   <= vld_s5;
			done_q   <= vld_s6 && qry_s6;
			member_q <= vld_s6 && qry_s6 && !nofilt_s6 && (xor_d == fp_s6);
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		item_s1 <= in_item;

		wr_s2  <= item_s1.is_write;
		qry_s2 <= item_s1.is_query;
		idx_s2 <= item_s1.index;
		val_s2 <= item_s1.value;
		x_s2   <= x_d;

		wr_s3  <= wr_s2;
		qry_s3 <= qry_s2;
		idx_s3 <= idx_s2;
		val_s3 <= val_s2;
		ll_s3  <= ll_d;
		cr_s3  <= cr_d;

		wr_s4  <= wr_s3;
		qry_s4 <= qry_s3;
		idx_s4 <= idx_s3;
		val_s4 <= val_s3;
		ll_s4  <= ll2_d;
		cr_s4  <= cr2_d;

		wr_s5  <= wr_s4;
		qry_s5 <= qry_s4;
		idx_s5 <= idx_s4;
		val_s5 <= val_s4;
		fp_s5  <= f_d[xfq_pkg::FP_LANE][xfq_pkg::FP_W-1:0];
		plo_s5 <= plo_d;
		phi_s5 <= phi_d;

		qry_s6    <= qry_s5;
		fp_s6     <= fp_s5;
		nofilt_s6 <= (len == '0);
	end

	assign done      = done_q;
	assign is_member = member_q;

endmodule

[rtl/core/xfq_checker.sv]
// Port-level checker for the xor-filter membership engine and the bind that
// attaches it to the top level. Depends on xfq_pkg.
module xfq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [xfq_pkg::FUNC_W-1:0] func,
	input logic                       done,
	input logic                       is_member
);

	localparam int LAT = xfq_pkg::LATENCY;

	logic query_taken;
	assign query_taken = start && !busy &&
		(func == xfq_pkg::FUNC_QKEY || func == xfq_pkg::FUNC_QPOINT);

	// A positive answer only appears with its strobe.
	a_member_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		is_member |-> done)
		else $error("is_member high without done");

	// Every accepted query is answered after the fixed latency.
	a_query_answered: assert property (@(posedge clk) disable iff (!arst_n)
		query_taken |-> ##LAT done)
		else $error("accepted query not answered on time");

	// No strobe appears without a query accepted at the matching edge.
	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(query_taken, LAT))
		else $error("done without a matching accepted query");

endmodule

bind xor_filter_membership_query xfq_checker u_xfq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.func      (func),
	.done      (done),
	.is_member (is_member)
);

[sim/tb_xor_filter_membership_query.sv]
// Self-checking testbench for xor_filter_membership_query: table writes and key/point
// queries against an in-bench predictor, under random idle gaps and several configurations.
// Depends on xfq_pkg and the xor_filter_membership_query RTL.
module tb_xor_filter_membership_query;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FUNC_W     = xfq_pkg::FUNC_W;
	localparam int IDX_W      = xfq_pkg::IDX_W;
	localparam int FP_W       = xfq_pkg::FP_W;
	localparam int KEY_W      = xfq_pkg::KEY_W;
	localparam int TAIL_W     = xfq_pkg::TAIL_W;
	localparam int SEG_W      = xfq_pkg::SEG_W;
	localparam int APB_ADDR_W = xfq_pkg::APB_ADDR_W;
	localparam int APB_DATA_W = xfq_pkg::APB_DATA_W;
	localparam int LATENCY    = xfq_pkg::LATENCY;
	localparam bit [FUNC_W-1:0] FUNC_WRITE  = xfq_pkg::FUNC_WRITE;
	localparam bit [FUNC_W-1:0] FUNC_QKEY   = xfq_pkg::FUNC_QKEY;
	localparam bit [FUNC_W-1:0] FUNC_QPOINT = xfq_pkg::FUNC_QPOINT;

	// Code 3 is not used by the engine: such a request is dropped without a result.
	localparam bit [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned SEG_LIMIT = xfq_pkg::MAX_SEGMENT_DEF;
	localparam int unsigned TABLE_DEPTH = 3 * SEG_LIMIT;
	localparam bit [KEY_W-1:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

	// Register index i sits at byte address 8*i since the seed is 64 bits wide.
	typedef enum bit {CFG_SEED, CFG_SEGLEN} cfg_reg_t;
	typedef enum bit {ROW_REQUEST, ROW_CONFIG} row_kind_t;
	// Where the expected answer of a directed row comes from.
	typedef enum bit [1:0] {PREDICTED, NO_RESULT, ANSWER_FALSE} answer_src_t;

	typedef struct {
		bit [FUNC_W-1:0] func;
		bit [IDX_W-1:0]  index;
		bit [FP_W-1:0]   value;
		bit [KEY_W-1:0]  key;
		bit [TAIL_W-1:0] tail;
	} request_t;

	typedef struct {
		row_kind_t       kind;
		cfg_reg_t        target;
		bit [FUNC_W-1:0] func;
		bit [IDX_W-1:0]  index;
		bit [FP_W-1:0]   value;
		bit [KEY_W-1:0]  key;       // also the register value of a config row
		bit [TAIL_W-1:0] tail;
		bit              make_member;
		answer_src_t     src;
	} step_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [FUNC_W-1:0]      func = '0;
	logic [IDX_W-1:0]       entry_index = '0;
	logic [FP_W-1:0]        entry_value = '0;
	logic [KEY_W-1:0]       key_value = '0;
	logic [TAIL_W-1:0]      point_tail = '0;
	logic                   done;
	logic                   is_member;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr = '0;
	logic [APB_DATA_W-1:0]  pwdata = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	// Mirror of the engine: configuration, fingerprint table and which entries hold data.
	bit [KEY_W-1:0] seed_mirror = '0;
	bit [SEG_W-1:0] seglen_mirror = '0;
	bit [FP_W-1:0]  fp_mirror [TABLE_DEPTH];
	bit             fp_loaded [TABLE_DEPTH];

	// Membership answers still owed by the engine, oldest first.
	bit member_expected [$];

	int failures = 0;
	int n_requests = 0;
	int n_writes = 0;
	int n_queries = 0;
	int n_ignored = 0;
	int n_cfg = 0;
	int n_results = 0;
	int n_hits = 0;
	bit calm = 1'b0;

	xor_filter_membership_query u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.key_value   (key_value),
		.point_tail  (point_tail),
		.done        (done),
		.is_member   (is_member),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #5 clk = ~clk;

	// The murmur-style finalizer used both for slot hashes and for the fingerprint.
	function automatic bit [KEY_W-1:0] mix_key(input bit [KEY_W-1:0] h);
		h = h ^ (h >> 33);
		h = h * 64'hff51afd7ed558ccd;
		h = h ^ (h >> 33);
		h = h * 64'hc4ceb9fe1a85ec53;
		h = h ^ (h >> 33);
		return h;
	endfunction

	// Multiply-high: maps a 64-bit hash uniformly onto 0 .. len-1.
	function automatic int unsigned scale_to_segment(input bit [KEY_W-1:0] h,
			input int unsigned len);
		bit [127:0] prod;
		prod = {64'd0, h} * 128'(len);
		return int'(prod[127:64]);
	endfunction

	// A 96-bit point folds its tail into both halves of the low word.
	function automatic bit [KEY_W-1:0] fold_point(input bit [KEY_W-1:0] low,
			input bit [TAIL_W-1:0] tail);
		return low ^ {32'd0, tail} ^ {tail, 32'd0};
	endfunction

	// Segment length actually in force: oversized values saturate to the segment limit.
	function automatic int unsigned usable_length();
		if (seglen_mirror > SEG_LIMIT)
			return SEG_LIMIT;
		return seglen_mirror;
	endfunction

	function automatic void locate_slots(input bit [KEY_W-1:0] k, input int unsigned len,
			output int unsigned p0, output int unsigned p1, output int unsigned p2);
		p0 = scale_to_segment(mix_key(k + seed_mirror), len);
		p1 = scale_to_segment(mix_key(k + seed_mirror + 64'd1), len) + len;
		p2 = scale_to_segment(mix_key(k + seed_mirror + 64'd2), len) + 2 * len;
	endfunction

	function automatic bit membership(input bit [KEY_W-1:0] k);
		int unsigned len;
		int unsigned p0, p1, p2;
		bit [KEY_W-1:0] fp;
		len = usable_length();
		if (len == 0)
			return 1'b0;
		locate_slots(k, len, p0, p1, p2);
		fp = mix_key(k);
		return (fp_mirror[p0] ^ fp_mirror[p1] ^ fp_mirror[p2]) == fp[FP_W-1:0];
	endfunction

	// Advances the mirror by one accepted request and tells whether it owes an answer.
	function automatic void apply_request(input request_t rq, output bit has, output bit ans);
		has = 1'b0;
		ans = 1'b0;
		case (rq.func)
			FUNC_WRITE: begin
				if (rq.index < TABLE_DEPTH) begin
					fp_mirror[rq.index] = rq.value;
					fp_loaded[rq.index] = 1'b1;
					n_writes++;
				end else begin
					n_ignored++;
				end
			end
			FUNC_QKEY: begin
				has = 1'b1;
				ans = membership(rq.key);
			end
			FUNC_QPOINT: begin
				has = 1'b1;
				ans = membership(fold_point(rq.key, rq.tail));
			end
			default: n_ignored++;
		endcase
		if (has)
			n_queries++;
	endfunction

	function automatic bit [KEY_W-1:0] random_key();
		case ($urandom_range(24))
			0: return '0;
			1: return ALL_ONES;
			2: return 64'd1 << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic request_t random_request(input bit [FUNC_W-1:0] fn);
		request_t rq;
		rq.func = fn;
		rq.index = IDX_W'($urandom_range(2 ** IDX_W - 1));
		rq.value = FP_W'($urandom_range(255));
		rq.key = random_key();
		rq.tail = ($urandom_range(9) == 0) ? {TAIL_W{1'b1}} : $urandom;
		return rq;
	endfunction

	// Holds start low for a few cycles while the payload wanders.
	task automatic pause_requests(input int cycles);
		request_t junk;
		junk = random_request(FUNC_W'($urandom_range(3)));
		start <= 1'b0;
		func <= junk.func;
		entry_index <= junk.index;
		entry_value <= junk.value;
		key_value <= junk.key;
		point_tail <= junk.tail;
		repeat (cycles) @(posedge clk);
	endtask

	// Presents one request, waits for the engine to take it, then books its answer.
	// start is left high so that a following request keeps it high without a dip.
	task automatic send_request(input request_t rq, input answer_src_t src);
		bit has;
		bit ans;
		if (!calm && $urandom_range(99) < 12)
			pause_requests($urandom_range(1, 4));
		start <= 1'b1;
		func <= rq.func;
		entry_index <= rq.index;
		entry_value <= rq.value;
		key_value <= rq.key;
		point_tail <= rq.tail;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_requests++;
		apply_request(rq, has, ans);
		if (src == ANSWER_FALSE) begin
			has = 1'b1;
			ans = 1'b0;
		end else if (src == NO_RESULT) begin
			has = 1'b0;
		end
		if (has)
			member_expected.insert(member_expected.size(), ans);
	endtask

	// A well-formed query: first loads any of its three entries that were never written,
	// and when make_member is set rewrites the last one so that the key is found.
	task automatic send_query(input bit [FUNC_W-1:0] fn, input bit [KEY_W-1:0] key,
			input bit [TAIL_W-1:0] tail, input bit make_member, input answer_src_t src);
		bit [KEY_W-1:0] k;
		bit [KEY_W-1:0] fp;
		int unsigned len;
		int unsigned pos [3];
		request_t rq;
		k = (fn == FUNC_QPOINT) ? fold_point(key, tail) : key;
		len = usable_length();
		if (len != 0) begin
			locate_slots(k, len, pos[0], pos[1], pos[2]);
			fp = mix_key(k);
			for (int i = 0; i < 3; i++) begin
				if (!fp_loaded[pos[i]] || (make_member && i == 2)) begin
					rq = random_request(FUNC_WRITE);
					rq.index = IDX_W'(pos[i]);
					if (make_member && i == 2)
						rq.value = fp[FP_W-1:0] ^ fp_mirror[pos[0]] ^ fp_mirror[pos[1]];
					send_request(rq, PREDICTED);
				end
			end
		end
		rq = random_request(fn);
		rq.key = key;
		rq.tail = tail;
		send_request(rq, src);
	endtask

	// Register write followed by a read-back, issued only once the engine has drained.
	task automatic set_register(input cfg_reg_t r, input bit [KEY_W-1:0] v);
		bit [APB_ADDR_W-1:0] addr;
		bit [APB_DATA_W-1:0] readback;
		addr = APB_ADDR_W'(int'(r) * 8);
		readback = (r == CFG_SEED) ? v : {51'd0, v[SEG_W-1:0]};
		start <= 1'b0;
		while (member_expected.size() != 0) @(posedge clk);
		// Table writes give no strobe, so allow the pipeline to empty as well.
		repeat (LATENCY + 2) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (r == CFG_SEED)
			seed_mirror = v;
		else
			seglen_mirror = v[SEG_W-1:0];
		n_cfg++;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== readback) begin
			$error("prdata: expected %h, actual %h", readback, prdata);
			failures++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Each done strobe is checked against the oldest answer still owed.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			n_results++;
			if (member_expected.size() == 0) begin
				$error("is_member: expected no result, actual %b", is_member);
				failures++;
			end else begin
				if (is_member === 1'b1)
					n_hits++;
				if (is_member !== member_expected[0]) begin
					$error("is_member: expected %b, actual %b", member_expected[0],
						is_member);
					failures++;
				end
				void'(member_expected.pop_front());
			end
		end
	end

	// Directed part. With no filter loaded every query must answer false; after that the
	// table goes through one entry per segment, an oversized length and the full size.
	step_row_t directed_rows [24] = '{
		'{ROW_REQUEST, CFG_SEED, FUNC_QKEY, 14'd0, 8'h00, 64'h0, 32'h0, 1'b0, ANSWER_FALSE},
		'{ROW_REQUEST, CFG_SEED, FUNC_QKEY, 14'd0, 8'h00, ALL_ONES, 32'h0, 1'b0, ANSWER_FALSE},
		'{ROW_REQUEST, CFG_SEED, FUNC_QPOINT, 14'd0, 8'h00, ALL_ONES, 32'hffff_ffff, 1'b0,
			ANSWER_FALSE},
		'{ROW_REQUEST, CFG_SEED, FUNC_QPOINT, 14'd0, 8'h00, 64'h0, 32'h8000_0001, 1'b0,
			ANSWER_FALSE},
		'{ROW_REQUEST, CFG_SEED, FUNC_UNUSED, 14'h3fff, 8'hff, ALL_ONES, 32'hffff_ffff, 1'b0,
			NO_RESULT},
		'{ROW_REQUEST, CFG_SEED, FUNC_WRITE, 14'd12288, 8'hff, 64'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_REQUEST, CFG_SEED, FUNC_WRITE, 14'h3fff, 8'hff, 64'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_REQUEST, CFG_SEED, FUNC_WRITE, 14'd0, 8'h00, 64'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_REQUEST, CFG_SEED, FUNC_WRITE, 14'd12287, 8'hff, 64'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_CONFIG, CFG_SEGLEN, FUNC_WRITE, 14'd0, 8'h00, 64'd1, 32'h0, 1'b0, PREDICTED},
		'{ROW_CONFIG, CFG_SEED, FUNC_WRITE, 14'd0, 8'h00, ALL_ONES, 32'h0, 1'b0, PREDICTED},
		'{ROW_REQUEST, CFG_SEED, FUNC_QKEY, 14'd0, 8'h00, 64'h0, 32'h0, 1'b0, PREDICTED},
		'{ROW_REQUEST, CFG_SEED, FUNC_QKEY, 14'd0, 8'h00, ALL_ONES, 32'h0, 1'b1, PREDICTED},
		'{ROW_REQUEST, CFG_SEED, FUNC_QPOINT, 14'd0, 8'h00, 64'h0, 32'hffff_ffff, 1'b1,
			PREDICTED},
		'{ROW_REQUEST, CFG_SEED, FUNC_QPOINT, 14'd0, 8'h00, ALL_ONES, 32'h0, 1'b0, PREDICTED},
		'{ROW_CONFIG, CFG_SEGLEN, FUNC_WRITE, 14'd0, 8'h00, 64'd8191, 32'h0, 1'b0, PREDICTED},
		'{ROW_CONFIG, CFG_SEED, FUNC_WRITE, 14'd0, 8'h00, 64'h0, 32'h0, 1'b0, PREDICTED},
		'{ROW_REQUEST, CFG_SEED, FUNC_QKEY, 14'd0, 8'h00, 64'h0, 32'h0, 1'b1, PREDICTED},
		'{ROW_REQUEST, CFG_SEED, FUNC_QKEY, 14'd0, 8'h00, ALL_ONES, 32'h0, 1'b0, PREDICTED},
		'{ROW_REQUEST, CFG_SEED, FUNC_QPOINT, 14'd0, 8'h00, 64'h0123_4567_89ab_cdef,
			32'hfedc_ba98, 1'b1, PREDICTED},
		'{ROW_CONFIG, CFG_SEGLEN, FUNC_WRITE, 14'd0, 8'h00, 64'd4096, 32'h0, 1'b0, PREDICTED},
		'{ROW_REQUEST, CFG_SEED, FUNC_QKEY, 14'd0, 8'h00, 64'h8000_0000_0000_0000, 32'h0,
			1'b0, PREDICTED},
		'{ROW_REQUEST, CFG_SEED, FUNC_WRITE, 14'd4095, 8'h5a, 64'h0, 32'h0, 1'b0, PREDICTED},
		'{ROW_REQUEST, CFG_SEED, FUNC_QPOINT, 14'd0, 8'h00, 64'h0000_0001_0000_0000,
			32'h1, 1'b1, PREDICTED}
	};

	initial begin
		step_row_t row;
		request_t rq;
		bit [KEY_W-1:0] seeds [5];
		bit [KEY_W-1:0] lengths [5];
		int counts [5];
		int stop_at;
		int pick;
		bit [FUNC_W-1:0] fn;

		// Random phases: full-size table, an oversized length that must saturate, a short
		// table run with no idle gaps at all, no filter loaded, and an odd random size.
		seeds = '{{$urandom, $urandom}, 64'h0, ALL_ONES, {$urandom, $urandom},
			{$urandom, $urandom}};
		lengths = '{64'd4096, 64'd8191, 64'($urandom_range(2, 64)), 64'd0,
			64'($urandom_range(1, 4095))};
		counts = '{110, 80, 100, 40, 120};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.kind == ROW_CONFIG) begin
				set_register(row.target, row.key);
			end else if (row.func == FUNC_QKEY || row.func == FUNC_QPOINT) begin
				send_query(row.func, row.key, row.tail, row.make_member, row.src);
			end else begin
				rq = '{row.func, row.index, row.value, row.key, row.tail};
				send_request(rq, row.src);
			end
		end

		// Mostly well-formed query sequences with random content; the rest is stray
		// writes (some beyond the table), unused codes and plain queries.
		for (int ph = 0; ph < 5; ph++) begin
			set_register(CFG_SEED, seeds[ph]);
			set_register(CFG_SEGLEN, lengths[ph]);
			calm = (ph == 2);
			stop_at = n_requests + counts[ph];
			while (n_requests < stop_at) begin
				pick = $urandom_range(99);
				fn = $urandom_range(1) ? FUNC_QPOINT : FUNC_QKEY;
				rq = random_request(fn);
				if (pick < 70) begin
					send_query(fn, rq.key, rq.tail, $urandom_range(1), PREDICTED);
				end else if (pick < 85) begin
					rq.func = FUNC_WRITE;
					send_request(rq, PREDICTED);
				end else if (pick < 92) begin
					rq.func = FUNC_UNUSED;
					send_request(rq, PREDICTED);
				end else begin
					send_query(fn, rq.key, rq.tail, 1'b0, PREDICTED);
				end
			end
		end
		calm = 1'b0;

		start <= 1'b0;
		while (member_expected.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		$display(
			"Covered %0d requests (%0d table writes, %0d queries, %0d ignored), %0d reg writes.",
			n_requests, n_writes, n_queries, n_ignored, n_cfg);
		$display("Checked %0d answers, %0d of them members, over five random configurations.",
			n_results, n_hits);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
